FILE: hw/rtl/fud_pkg.sv
// Shared constants, types and a helper function for the form item decoder.
`default_nettype none

package fud_pkg;

  localparam int FUD_LENGTH_BITS = 24;
  localparam int FUD_ITEM_COUNT_BITS = 12;
  localparam int FUD_QUEUE_DEPTH = 4;
  localparam int FUD_LEN_MAX_BITS = 16;

  localparam int FUD_CFG_LEN_BITS = 24;
  localparam int FUD_CFG_CAP_BITS = 13;
  localparam int FUD_ADDR_BITS = 3;
  localparam int FUD_DATA_BITS = 32;

  localparam logic [0:0] REG_CONTENT_LENGTH = 1'b0;
  localparam logic [0:0] REG_ITEM_CAPACITY = 1'b1;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] CAUSE_EQUALS = 2'd0;
  localparam logic [1:0] CAUSE_AMP = 2'd1;
  localparam logic [1:0] CAUSE_END = 2'd2;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef struct packed {
    logic                        st_valid;
    logic [7:0]                  st_char;
    logic                        end_valid;
    logic [FUD_LEN_MAX_BITS-1:0] end_len;
    logic [1:0]                  end_cause;
  } fud_entry_t;

  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [7:0] diff;
    diff = 8'd0;
    if (ch inside {[8'h30:8'h39]}) begin
      diff = ch - 8'h30;
    end else if (ch inside {[8'h61:8'h66]}) begin
      diff = ch - 8'h57;
    end else if (ch inside {[8'h41:8'h46]}) begin
      diff = ch - 8'h37;
    end
    return diff[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fud_front.sv
// Front end: accepts raw body bytes, tracks escape state and builds queue entries.
`default_nettype none

module fud_front #(
  parameter int LENGTH_BITS = fud_pkg::FUD_LENGTH_BITS,
  parameter int ITEM_COUNT_BITS = fud_pkg::FUD_ITEM_COUNT_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             data_byte,
  input  logic                                   source_dry,
  input  logic                                   len_load,
  input  logic [fud_pkg::FUD_CFG_LEN_BITS-1:0]   len_value,
  input  logic [fud_pkg::FUD_CFG_CAP_BITS-1:0]   item_capacity,
  input  logic                                   q_full,
  output logic                                   q_push,
  output fud_pkg::fud_entry_t                    q_data
);
  import fud_pkg::*;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_HIGH = 2'd1;
  localparam logic [1:0] MODE_LOW = 2'd2;
  localparam logic [16:0] CountMax = 17'((1 << ITEM_COUNT_BITS) - 1);

  logic [1:0]                 decode_mode, decode_mode_next;
  logic [3:0]                 high_nibble, high_nibble_next;
  logic [ITEM_COUNT_BITS-1:0] kept_count, kept_count_next;
  logic [LENGTH_BITS-1:0]     bytes_remaining;

  logic                       accept;
  logic                       eof;
  logic [16:0]                cap_limit;
  logic [16:0]                limit;
  logic                       can_store;
  logic [ITEM_COUNT_BITS-1:0] kept_plus;
  fud_entry_t                 entry;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign eof = (bytes_remaining == '0) || source_dry;

  assign cap_limit = (item_capacity == '0) ? 17'd0 : 17'(item_capacity) - 17'd1;
  assign limit = (cap_limit > CountMax) ? CountMax : cap_limit;
  assign can_store = 17'(kept_count) < limit;
  assign kept_plus = can_store ? kept_count + 1'b1 : kept_count;

  always_comb begin
    decode_mode_next = MODE_NORMAL;
    high_nibble_next = high_nibble;
    kept_count_next = kept_count;
    entry = '0;
    case (decode_mode)
      MODE_HIGH: begin
        if (eof) begin
          entry.st_valid = can_store;
          entry.st_char = 8'd0;
          entry.end_valid = 1'b1;
          entry.end_len = FUD_LEN_MAX_BITS'(kept_plus);
          entry.end_cause = CAUSE_END;
          kept_count_next = '0;
        end else begin
          high_nibble_next = hex_value(data_byte);
          decode_mode_next = MODE_LOW;
        end
      end
      MODE_LOW: begin
        entry.st_valid = can_store;
        entry.st_char = {high_nibble, eof ? 4'd0 : hex_value(data_byte)};
        if (eof) begin
          entry.end_valid = 1'b1;
          entry.end_len = FUD_LEN_MAX_BITS'(kept_plus);
          entry.end_cause = CAUSE_END;
          kept_count_next = '0;
        end else begin
          kept_count_next = kept_plus;
        end
      end
      default: begin
        if (eof) begin
          entry.end_valid = 1'b1;
          entry.end_len = FUD_LEN_MAX_BITS'(kept_count);
          entry.end_cause = CAUSE_END;
          kept_count_next = '0;
        end else begin
          case (data_byte)
            CH_EQUALS: begin
              entry.end_valid = 1'b1;
              entry.end_len = FUD_LEN_MAX_BITS'(kept_count);
              entry.end_cause = CAUSE_EQUALS;
              kept_count_next = '0;
            end
            CH_AMP: begin
              entry.end_valid = 1'b1;
              entry.end_len = FUD_LEN_MAX_BITS'(kept_count);
              entry.end_cause = CAUSE_AMP;
              kept_count_next = '0;
            end
            CH_PERCENT: begin
              decode_mode_next = MODE_HIGH;
            end
            CH_PLUS: begin
              entry.st_valid = can_store;
              entry.st_char = CH_SPACE;
              kept_count_next = kept_plus;
            end
            default: begin
              entry.st_valid = can_store;
              entry.st_char = data_byte;
              kept_count_next = kept_plus;
            end
          endcase
        end
      end
    endcase
  end

  assign q_push = accept && (entry.st_valid || entry.end_valid);
  assign q_data = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= MODE_NORMAL;
      high_nibble <= 4'd0;
      kept_count <= '0;
    end else if (accept) begin
      decode_mode <= decode_mode_next;
      high_nibble <= high_nibble_next;
      kept_count <= kept_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
    end else if (len_load) begin
      bytes_remaining <= LENGTH_BITS'(len_value);
    end else if (accept && (bytes_remaining != '0)) begin
      bytes_remaining <= bytes_remaining - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fud_queue.sv
// Short queue of decoded entries between the front end and the output stage.
`default_nettype none

module fud_queue #(
  parameter int DEPTH = fud_pkg::FUD_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fud_pkg::fud_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output fud_pkg::fud_entry_t pop_data
);
  import fud_pkg::*;

  localparam int PtrBits = $clog2(DEPTH);
  localparam int CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] DepthCount = CntBits'(DEPTH);

  fud_entry_t         slots [DEPTH];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [CntBits-1:0] count;

  assign full = (count == DepthCount);
  assign q_valid = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fud_back.sv
// Output stage: turns each queue entry into one or two result requests.
`default_nettype none

module fud_back #(
  parameter int ITEM_COUNT_BITS = fud_pkg::FUD_ITEM_COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  fud_pkg::fud_entry_t        q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       kind,
  output logic [7:0]                 char_value,
  output logic [ITEM_COUNT_BITS-1:0] item_length,
  output logic [1:0]                 end_cause,
  output logic                       last
);
  import fud_pkg::*;

  fud_entry_t cur;
  logic       cur_valid;
  logic       phase;
  logic       show_char;
  logic       fire;
  logic       finishing;
  logic       free;

  assign show_char = cur.st_valid && !phase;
  assign fire = cur_valid && out_ready;
  assign finishing = fire && !(show_char && cur.end_valid);
  assign free = !cur_valid || finishing;
  assign q_pop = free && q_valid;

  assign out_valid = cur_valid;
  assign kind = show_char ? KIND_CHAR : KIND_END;
  assign char_value = show_char ? cur.st_char : 8'd0;
  assign item_length = show_char ? '0 : cur.end_len[ITEM_COUNT_BITS-1:0];
  assign end_cause = show_char ? CAUSE_EQUALS : cur.end_cause;
  assign last = show_char ? !cur.end_valid : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase <= 1'b0;
    end else if (free) begin
      cur_valid <= q_valid;
      phase <= 1'b0;
    end else if (fire) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/form_urlencoded_item_decoder.sv
// Top level of the form item decoder: configuration registers and the three stages.
//
// Raw body bytes enter on the input channel (in_valid/in_ready, data_byte,
// source_dry), one byte per request. Decoded results leave on the output
// channel (out_valid/out_ready, kind, char_value, item_length, end_cause,
// last), where each byte gives zero, one or two result requests.
// The front end takes one byte per cycle while the queue has room. A result is
// registered first in the queue and then in the output stage before it appears
// on the output. Bytes accepted at the end of the body while an escape is pending
// can produce two results; all other bytes produce one result or none. The queue
// holds four entries, so the input keeps flowing while the receiver stalls until
// the queue is full, and then in_ready drops until space frees up. Reset empties
// the queue, leaves the escape state normal, sets the content length and the
// remaining count to zero and the item capacity to 256. Writing the body length
// register also reloads the remaining byte count. The user must write the registers
// over the APB port only while no bytes are in flight; the block does not check it.
`default_nettype none

module form_urlencoded_item_decoder #(
  parameter int LENGTH_BITS = fud_pkg::FUD_LENGTH_BITS,
  parameter int ITEM_COUNT_BITS = fud_pkg::FUD_ITEM_COUNT_BITS,
  parameter int QUEUE_DEPTH = fud_pkg::FUD_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fud_pkg::FUD_ADDR_BITS-1:0]   paddr,
  input  logic [fud_pkg::FUD_DATA_BITS-1:0]   pwdata,
  output logic [fud_pkg::FUD_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          data_byte,
  input  logic                                source_dry,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                kind,
  output logic [7:0]                          char_value,
  output logic [ITEM_COUNT_BITS-1:0]          item_length,
  output logic [1:0]                          end_cause,
  output logic                                last
);
  import fud_pkg::*;

  logic [FUD_CFG_LEN_BITS-1:0] body_length;
  logic [FUD_CFG_CAP_BITS-1:0] item_capacity;
  logic                        wr_en;
  logic                        len_load;
  logic                        q_full;
  logic                        q_push;
  logic                        q_pop;
  logic                        q_valid;
  fud_entry_t                  q_in;
  fud_entry_t                  q_out;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign len_load = wr_en && (paddr[2:2] == REG_CONTENT_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      body_length <= '0;
      item_capacity <= FUD_CFG_CAP_BITS'(256);
    end else if (wr_en) begin
      case (paddr[2:2])
        REG_CONTENT_LENGTH: body_length <= pwdata[FUD_CFG_LEN_BITS-1:0];
        REG_ITEM_CAPACITY: item_capacity <= pwdata[FUD_CFG_CAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2:2])
      REG_CONTENT_LENGTH: prdata = FUD_DATA_BITS'(body_length);
      REG_ITEM_CAPACITY: prdata = FUD_DATA_BITS'(item_capacity);
      default: prdata = '0;
    endcase
  end

  fud_front #(
    .LENGTH_BITS(LENGTH_BITS),
    .ITEM_COUNT_BITS(ITEM_COUNT_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .source_dry(source_dry),
    .len_load(len_load),
    .len_value(pwdata[FUD_CFG_LEN_BITS-1:0]),
    .item_capacity(item_capacity),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_in)
  );

  fud_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(q_in),
    .full(q_full),
    .pop(q_pop),
    .q_valid(q_valid),
    .pop_data(q_out)
  );

  fud_back #(
    .ITEM_COUNT_BITS(ITEM_COUNT_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_data(q_out),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .char_value(char_value),
    .item_length(item_length),
    .end_cause(end_cause),
    .last(last)
  );

endmodule

`default_nettype wire
